FILE: hw/rtl/qvr_pkg.sv
`timescale 1ns / 1ps
package qvr_pkg;

  localparam int QF = 13;
  localparam int VW = 16;
  localparam int QW = 16;
  localparam int N2W = 33;
  localparam int RTW = 17;
  localparam int QNW = 15;
  localparam int TW = 18;
  localparam int DQB = 14;
  localparam int SQ_STAGES = 17;
  localparam int DIV_LAT = DQB + 1;
  localparam int ROT_LAT = 4;
  localparam int LATENCY = 2 + SQ_STAGES + DIV_LAT + ROT_LAT;

  typedef struct packed {
    logic signed [QW-1:0] w;
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] z;
  } quat_t;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [VW-1:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [QNW-1:0] w;
    logic signed [QNW-1:0] x;
    logic signed [QNW-1:0] y;
    logic signed [QNW-1:0] z;
  } qn_t;

  // round to nearest, ties away from zero
  function automatic logic signed [47:0] rnd_shift(input logic signed [47:0] x, input int s);
    logic [47:0] mag;
    logic neg;
    neg = x[47];
    mag = neg ? 48'(-x) : 48'(x);
    mag = (mag + (48'd1 << (s - 1))) >> s;
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

FILE: hw/rtl/qvr_sqrt.sv
`timescale 1ns / 1ps
module qvr_sqrt (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [32:0]        n2_i,
  input  qvr_pkg::quat_t     q_i,
  input  qvr_pkg::vec_t      v_i,
  output logic               valid_o,
  output logic [16:0]        root_o,
  output qvr_pkg::quat_t     q_o,
  output qvr_pkg::vec_t      v_o
);
  import qvr_pkg::*;

  logic              vld_q  [0:SQ_STAGES];
  logic [19:0]       rem_q  [0:SQ_STAGES];
  logic [RTW-1:0]    root_q [0:SQ_STAGES];
  logic [33:0]       n_q    [0:SQ_STAGES];
  quat_t             qq     [0:SQ_STAGES];
  vec_t              vq     [0:SQ_STAGES];

  assign vld_q[0]  = valid_i;
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign n_q[0]    = {1'b0, n2_i};
  assign qq[0]     = q_i;
  assign vq[0]     = v_i;

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
    localparam int I = SQ_STAGES - 1 - k;
    logic [19:0] sh_d, trial_d, rem_d;
    logic [RTW-1:0] root_d;
    always_comb begin
      sh_d    = {rem_q[k][17:0], n_q[k][2*I+1 -: 2]};
      trial_d = {1'b0, root_q[k], 2'b01};
      if (sh_d >= trial_d) begin
        rem_d  = sh_d - trial_d;
        root_d = {root_q[k][RTW-2:0], 1'b1};
      end else begin
        rem_d  = sh_d;
        root_d = {root_q[k][RTW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      rem_q[k+1]  <= rem_d;
      root_q[k+1] <= root_d;
      n_q[k+1]    <= n_q[k];
      qq[k+1]     <= qq[k];
      vq[k+1]     <= vq[k];
    end
  end

  assign valid_o = vld_q[SQ_STAGES];
  assign root_o  = root_q[SQ_STAGES];
  assign q_o     = qq[SQ_STAGES];
  assign v_o     = vq[SQ_STAGES];

endmodule

FILE: hw/rtl/qvr_div.sv
`timescale 1ns / 1ps
module qvr_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [16:0]        root_i,
  input  logic               degen_i,
  input  qvr_pkg::quat_t     q_i,
  input  qvr_pkg::vec_t      v_i,
  output logic               valid_o,
  output qvr_pkg::qn_t       qn_o,
  output logic               degen_o,
  output qvr_pkg::vec_t      v_o
);
  import qvr_pkg::*;

  logic            vld_q  [0:DQB];
  logic [17:0]     den_q  [0:DQB];
  logic            dg_q   [0:DQB];
  vec_t            vq     [0:DQB];
  logic [29:0]     num_q  [0:3][0:DQB];
  logic [18:0]     rem_q  [0:3][0:DQB];
  logic [DQB-1:0]  quo_q  [0:3][0:DQB];
  logic            neg_q  [0:3][0:DQB];
  logic [QW-1:0]   q_arr  [0:3];

  assign q_arr[0] = q_i.w;
  assign q_arr[1] = q_i.x;
  assign q_arr[2] = q_i.y;
  assign q_arr[3] = q_i.z;

  assign vld_q[0] = valid_i;
  assign den_q[0] = {root_i, 1'b0};
  assign dg_q[0]  = degen_i;
  assign vq[0]    = v_i;

  for (genvar c = 0; c < 4; c++) begin : g_init
    logic [QW-1:0] mag;
    logic [29:0] num;
    assign mag = q_arr[c][QW-1] ? QW'(-q_arr[c]) : q_arr[c];
    assign num = {mag, 14'd0} + 30'(root_i);
    assign num_q[c][0] = num;
    assign rem_q[c][0] = 19'(num[29:14]);
    assign quo_q[c][0] = '0;
    assign neg_q[c][0] = q_arr[c][QW-1];
  end

  for (genvar k = 0; k < DQB; k++) begin : g_stage
    localparam int I = DQB - 1 - k;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      den_q[k+1] <= den_q[k];
      dg_q[k+1]  <= dg_q[k];
      vq[k+1]    <= vq[k];
    end
    for (genvar c = 0; c < 4; c++) begin : g_comp
      logic [18:0] sh_d;
      logic ge_d;
      assign sh_d = {rem_q[c][k][17:0], num_q[c][k][I]};
      assign ge_d = sh_d >= {1'b0, den_q[k]};
      always_ff @(posedge clk_i) begin
        rem_q[c][k+1] <= ge_d ? sh_d - {1'b0, den_q[k]} : sh_d;
        quo_q[c][k+1] <= {quo_q[c][k][DQB-2:0], ge_d};
        num_q[c][k+1] <= num_q[c][k];
        neg_q[c][k+1] <= neg_q[c][k];
      end
    end
  end

  logic signed [QNW-1:0] qs [0:3];
  for (genvar c = 0; c < 4; c++) begin : g_sign
    assign qs[c] = neg_q[c][DQB] ? -$signed({1'b0, quo_q[c][DQB]})
                                 : $signed({1'b0, quo_q[c][DQB]});
  end

  logic vld_out_q, dg_out_q;
  qn_t qn_out_q;
  vec_t v_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_out_q <= 1'b0;
    end else begin
      vld_out_q <= vld_q[DQB];
    end
  end

  always_ff @(posedge clk_i) begin
    dg_out_q <= dg_q[DQB];
    v_out_q  <= vq[DQB];
    if (dg_q[DQB]) begin
      qn_out_q.w <= QNW'(1 << QF);
      qn_out_q.x <= '0;
      qn_out_q.y <= '0;
      qn_out_q.z <= '0;
    end else begin
      qn_out_q.w <= qs[0];
      qn_out_q.x <= qs[1];
      qn_out_q.y <= qs[2];
      qn_out_q.z <= qs[3];
    end
  end

  assign valid_o = vld_out_q;
  assign qn_o    = qn_out_q;
  assign degen_o = dg_out_q;
  assign v_o     = v_out_q;

endmodule

FILE: hw/rtl/qvr_rotate.sv
`timescale 1ns / 1ps
module qvr_rotate (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  qvr_pkg::qn_t       qn_i,
  input  logic               degen_i,
  input  qvr_pkg::vec_t      v_i,
  output logic               valid_o,
  output qvr_pkg::vec_t      rot_o,
  output logic               degen_o
);
  import qvr_pkg::*;

  logic vld1_q, vld2_q, vld3_q, vld4_q;
  logic dg1_q, dg2_q, dg3_q, dg4_q;
  logic signed [QNW-1:0] w1_q, w2_q;
  logic signed [QNW-1:0] qv1_q [0:2];
  logic signed [QNW-1:0] qv2_q [0:2];
  logic signed [VW-1:0]  v1_q [0:2];
  logic signed [VW-1:0]  v2_q [0:2];
  logic signed [VW-1:0]  v3_q [0:2];
  logic signed [30:0]    pa_q [0:2];
  logic signed [30:0]    pb_q [0:2];
  logic signed [TW-1:0]  t_q  [0:2];
  logic signed [32:0]    wt_q [0:2];
  logic signed [32:0]    ca_q [0:2];
  logic signed [32:0]    cb_q [0:2];
  logic signed [VW-1:0]  rot_q [0:2];
  logic signed [QNW-1:0] qv_in [0:2];
  logic signed [VW-1:0]  v_in  [0:2];

  assign qv_in[0] = qn_i.x;
  assign qv_in[1] = qn_i.y;
  assign qv_in[2] = qn_i.z;
  assign v_in[0]  = v_i.x;
  assign v_in[1]  = v_i.y;
  assign v_in[2]  = v_i.z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
    end else begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dg1_q <= degen_i;
    dg2_q <= dg1_q;
    dg3_q <= dg2_q;
    dg4_q <= dg3_q;
    w1_q  <= qn_i.w;
    w2_q  <= w1_q;
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int A = (i + 1) % 3;
    localparam int B = (i + 2) % 3;
    logic signed [47:0] t_d, sum_d;
    always_comb begin
      t_d = rnd_shift(48'(pa_q[i]), QF - 1) - rnd_shift(48'(pb_q[i]), QF - 1);
      sum_d = 48'(v3_q[i]) + rnd_shift(48'(wt_q[i]), QF)
            + rnd_shift(48'(ca_q[i]), QF) - rnd_shift(48'(cb_q[i]), QF);
    end
    always_ff @(posedge clk_i) begin
      qv1_q[i] <= qv_in[i];
      v1_q[i]  <= v_in[i];
      pa_q[i]  <= 31'(qv_in[A] * v_in[B]);
      pb_q[i]  <= 31'(qv_in[B] * v_in[A]);
      qv2_q[i] <= qv1_q[i];
      v2_q[i]  <= v1_q[i];
      t_q[i]   <= TW'(t_d);
      v3_q[i]  <= v2_q[i];
      wt_q[i]  <= 33'(w2_q * t_q[i]);
      ca_q[i]  <= 33'(qv2_q[A] * t_q[B]);
      cb_q[i]  <= 33'(qv2_q[B] * t_q[A]);
      if (sum_d > 48'sd32767) begin
        rot_q[i] <= 16'sh7fff;
      end else if (sum_d < -48'sd32768) begin
        rot_q[i] <= 16'sh8000;
      end else begin
        rot_q[i] <= VW'(sum_d);
      end
    end
  end

  assign valid_o = vld4_q;
  assign rot_o   = {rot_q[0], rot_q[1], rot_q[2]};
  assign degen_o = dg4_q;

endmodule

FILE: hw/rtl/quaternion_vector_rotate_top.sv
`timescale 1ns / 1ps
// Rotates a vector by a raw quaternion that is normalized on the fly. One item
// may be started every clock cycle and busy never rises; the result appears
// on the result ports for one cycle, marked by result_valid_o, once the start
// transfer passes the input registers, the pipelined square root (one root bit
// per stage), the pipelined divider (one quotient bit per stage) and the rotator.
// The receiver cannot stall, so it must take each result when it is shown.
// min_norm is written through the cfg channel, which is always ready; write it
// only while no item is in flight.
module quaternion_vector_rotate_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic signed [15:0]    quat_w_i,
  input  logic signed [15:0]    quat_x_i,
  input  logic signed [15:0]    quat_y_i,
  input  logic signed [15:0]    quat_z_i,
  input  logic signed [15:0]    vec_x_i,
  input  logic signed [15:0]    vec_y_i,
  input  logic signed [15:0]    vec_z_i,
  output logic                  result_valid_o,
  output logic signed [15:0]    rot_x_o,
  output logic signed [15:0]    rot_y_o,
  output logic signed [15:0]    rot_z_o,
  output logic                  degenerate_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [14:0]           cfg_data_i
);
  import qvr_pkg::*;

  logic [14:0] min_norm_q;
  logic s1_vld_q, s2_vld_q;
  logic [31:0] sq_q [0:3];
  logic [32:0] n2_q;
  quat_t q1_q, q2_q;
  vec_t v1_q, v2_q;

  assign busy = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_norm_q <= 15'd1;
      s1_vld_q   <= 1'b0;
      s2_vld_q   <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        min_norm_q <= cfg_data_i;
      end
      s1_vld_q <= start && !busy;
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    q1_q  <= '{w: quat_w_i, x: quat_x_i, y: quat_y_i, z: quat_z_i};
    v1_q  <= '{x: vec_x_i, y: vec_y_i, z: vec_z_i};
    sq_q[0] <= 32'(quat_w_i * quat_w_i);
    sq_q[1] <= 32'(quat_x_i * quat_x_i);
    sq_q[2] <= 32'(quat_y_i * quat_y_i);
    sq_q[3] <= 32'(quat_z_i * quat_z_i);
    n2_q  <= 33'(sq_q[0]) + 33'(sq_q[1]) + 33'(sq_q[2]) + 33'(sq_q[3]);
    q2_q  <= q1_q;
    v2_q  <= v1_q;
  end

  logic sq_vld;
  logic [16:0] root;
  quat_t sq_q_out;
  vec_t sq_v_out;

  qvr_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_vld_q),
    .n2_i    (n2_q),
    .q_i     (q2_q),
    .v_i     (v2_q),
    .valid_o (sq_vld),
    .root_o  (root),
    .q_o     (sq_q_out),
    .v_o     (sq_v_out)
  );

  logic degen;
  assign degen = root <= {2'b00, min_norm_q};

  logic dv_vld, dv_degen;
  qn_t qn;
  vec_t dv_v;

  qvr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_vld),
    .root_i  (root),
    .degen_i (degen),
    .q_i     (sq_q_out),
    .v_i     (sq_v_out),
    .valid_o (dv_vld),
    .qn_o    (qn),
    .degen_o (dv_degen),
    .v_o     (dv_v)
  );

  vec_t rot;

  qvr_rotate u_rotate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dv_vld),
    .qn_i    (qn),
    .degen_i (dv_degen),
    .v_i     (dv_v),
    .valid_o (result_valid_o),
    .rot_o   (rot),
    .degen_o (degenerate_o)
  );

  assign rot_x_o = rot.x;
  assign rot_y_o = rot.y;
  assign rot_z_o = rot.z;

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start, LATENCY))
    else $error("result without matching start");

  a_qn_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_vld |-> (qn.w <= 15'sd8192 && qn.w >= -15'sd8192))
    else $error("normalized scalar part out of range");

  a_degen_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_vld && dv_degen) |-> (qn.x == '0 && qn.y == '0 && qn.z == '0))
    else $error("degenerate item without identity quaternion");
`endif

endmodule
